// ===== hw/rtl/ibc_pkg.sv =====
// ibc_pkg: shared constants, codes and control types for the IMU bias calibrator.
// No dependencies; every rtl file refers to it by scoped names.
`timescale 1ns / 1ps

package ibc_pkg;

    // default widths of the sample fields and the sample counter
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 20;

    // fixed widths of the result offsets and the registers
    localparam int OUT_BITS      = 16;
    localparam int DUR_BITS      = 16;
    localparam int GRAV_BITS     = 15;
    localparam int MINS_BITS     = 20;
    localparam int CFG_DATA_BITS = 20;
    localparam int CFG_IDX_BITS  = 2;
    localparam int FUNC_BITS     = 2;
    localparam int STATUS_BITS   = 3;

    // six running sums: gyro x, y, z then accel x, y, z
    localparam int NUM_AXES  = 6;
    localparam int AXIS_BITS = 3;
    localparam logic [AXIS_BITS-1:0] AXIS_ACCEL_Z = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_DURATION = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GRAVITY  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_SMP  = 2'd2;

    // register reset values
    localparam logic [DUR_BITS-1:0]  DURATION_RST = 16'd1000;
    localparam logic [GRAV_BITS-1:0] GRAVITY_RST  = 15'd16384;
    localparam logic [MINS_BITS-1:0] MIN_SMP_RST  = 20'd10;

    // transaction kinds
    localparam logic [FUNC_BITS-1:0] FUNC_START  = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_TICK   = 2'd2;

    // result status codes
    localparam logic [STATUS_BITS-1:0] STAT_STARTED = 3'd0;
    localparam logic [STATUS_BITS-1:0] STAT_BUSY    = 3'd1;
    localparam logic [STATUS_BITS-1:0] STAT_SAMPLE  = 3'd2;
    localparam logic [STATUS_BITS-1:0] STAT_TICK    = 3'd3;
    localparam logic [STATUS_BITS-1:0] STAT_VALID   = 3'd4;
    localparam logic [STATUS_BITS-1:0] STAT_INSUF   = 3'd5;

    // control of the serial accumulator
    typedef struct packed {
        logic clear;
        logic load;
        logic shift;
    } acc_ctl_t;

endpackage

// ===== hw/rtl/ibc_serial_acc.sv =====
// ibc_serial_acc: six running sums updated by bit-serial addition, LSB first.
// Depends on ibc_pkg for the axis count and the control struct.
`timescale 1ns / 1ps

module ibc_serial_acc #(
    parameter int SAMPLE_BITS = ibc_pkg::SAMPLE_BITS_DEF,
    parameter int SUM_BITS    = ibc_pkg::SAMPLE_BITS_DEF + ibc_pkg::COUNT_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  ibc_pkg::acc_ctl_t                             ctl,
    input  logic [ibc_pkg::NUM_AXES-1:0][SAMPLE_BITS-1:0] samples,
    output logic [ibc_pkg::NUM_AXES-1:0][SUM_BITS-1:0]    sums
);

    logic [ibc_pkg::NUM_AXES-1:0][SUM_BITS-1:0]    sum_reg;
    logic [ibc_pkg::NUM_AXES-1:0][SUM_BITS-1:0]    sum_next;
    logic [ibc_pkg::NUM_AXES-1:0][SAMPLE_BITS-1:0] smp_reg;
    logic [ibc_pkg::NUM_AXES-1:0][SAMPLE_BITS-1:0] smp_next;
    logic [ibc_pkg::NUM_AXES-1:0]                  carry_reg;
    logic [ibc_pkg::NUM_AXES-1:0]                  carry_next;

    // one full adder per axis; the sample register repeats its sign bit as it drains
    always_comb
    begin
        sum_next   = sum_reg;
        smp_next   = smp_reg;
        carry_next = carry_reg;
        for (int i = 0; i < ibc_pkg::NUM_AXES; i++)
        begin
            if (ctl.clear)
            begin
                sum_next[i] = '0;
            end
            else if (ctl.load)
            begin
                smp_next[i]   = samples[i];
                carry_next[i] = 1'b0;
            end
            else if (ctl.shift)
            begin
                sum_next[i] = {sum_reg[i][0] ^ smp_reg[i][0] ^ carry_reg[i],
                               sum_reg[i][SUM_BITS-1:1]};
                carry_next[i] = (sum_reg[i][0] & smp_reg[i][0])
                              | (sum_reg[i][0] & carry_reg[i])
                              | (smp_reg[i][0] & carry_reg[i]);
                smp_next[i] = {smp_reg[i][SAMPLE_BITS-1], smp_reg[i][SAMPLE_BITS-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            carry_reg <= '0;
        end
        else
        begin
            sum_reg   <= sum_next;
            carry_reg <= carry_next;
        end
    end

    // sample digits are payload and need no reset
    always_ff @(posedge clk)
    begin
        smp_reg <= smp_next;
    end

    assign sums = sum_reg;

endmodule

// ===== hw/rtl/ibc_serial_div.sv =====
// ibc_serial_div: restoring divider, one quotient bit per cycle, with 16-bit saturation
// and optional gravity removal. Depends on ibc_pkg for output and gravity widths.
`timescale 1ns / 1ps

module ibc_serial_div #(
    parameter int SUM_BITS   = ibc_pkg::SAMPLE_BITS_DEF + ibc_pkg::COUNT_BITS_DEF,
    parameter int COUNT_BITS = ibc_pkg::COUNT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          go,
    input  logic                          is_z,
    input  logic [SUM_BITS-1:0]           dividend,
    input  logic [COUNT_BITS-1:0]         divisor,
    input  logic [ibc_pkg::GRAV_BITS-1:0] gravity,
    output logic                          done,
    output logic [ibc_pkg::OUT_BITS-1:0]  result
);

    localparam int CNT_BITS = $clog2(SUM_BITS + 1);
    localparam int OB       = ibc_pkg::OUT_BITS;

    logic                run_reg;
    logic                fin_reg;
    logic                done_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                neg_reg;
    logic                z_reg;
    logic [SUM_BITS-1:0] quo_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [OB-1:0]       res_reg;

    logic [COUNT_BITS:0] trial;
    logic [COUNT_BITS:0] diff;
    logic                ge;
    logic [OB-1:0]       sat_val;

    // trial subtract of the next remainder
    assign trial = {rem_reg, quo_reg[SUM_BITS-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};

    // sign the quotient magnitude, remove gravity if asked, clamp to 16 bits
    always_comb
    begin
        logic                big;
        logic signed [OB+1:0] mag;
        logic signed [OB+1:0] grv;
        logic signed [OB+1:0] val;
        big = (quo_reg >> OB) != '0;
        mag = {2'b00, quo_reg[OB-1:0]};
        grv = {{(OB + 2 - ibc_pkg::GRAV_BITS){1'b0}}, gravity};
        if (neg_reg)
        begin
            val = z_reg ? (-mag - grv) : -mag;
        end
        else
        begin
            val = z_reg ? (mag - grv) : mag;
        end
        if (big)
        begin
            sat_val = neg_reg ? {1'b1, {(OB-1){1'b0}}} : {1'b0, {(OB-1){1'b1}}};
        end
        else if (val > $signed({3'b000, {(OB-1){1'b1}}}))
        begin
            sat_val = {1'b0, {(OB-1){1'b1}}};
        end
        else if (val < $signed({3'b111, {(OB-1){1'b0}}}))
        begin
            sat_val = {1'b1, {(OB-1){1'b0}}};
        end
        else
        begin
            sat_val = val[OB-1:0];
        end
    end

    // sequence: load, SUM_BITS steps, then clamp and register the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_BITS'(SUM_BITS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_BITS'(1))
                begin
                    run_reg <= 1'b0;
                    fin_reg <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // datapath: take magnitude on load, shift quotient bits in on each step
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            neg_reg <= dividend[SUM_BITS-1];
            z_reg   <= is_z;
            quo_reg <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
            quo_reg <= {quo_reg[SUM_BITS-2:0], ge};
        end
        if (fin_reg)
        begin
            res_reg <= sat_val;
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ===== hw/rtl/imu_bias_calibrator_unit.sv =====
// imu_bias_calibrator_unit: top level, command control, counters, held offsets.
// Depends on ibc_pkg, ibc_serial_acc and ibc_serial_div.
//
//  channel   | ports                                   | transaction
//  ----------+-----------------------------------------+----------------------------
//  command   | start, busy, func, accel_*, gyro_*      | start high while busy low
//  result    | done, status, calibrating,              | done high for one cycle
//            | offsets_valid, gyro_off_*, accel_off_*  |
//  config    | cfg_we, cfg_index, cfg_wdata            | cfg_we high at clock edge
//
// An accepted sample is summed by the bit-serial adders of the sums while busy is high.
// A window-closing valid tick uses the shared one-bit-per-cycle divider walking the six
// axes in turn. SUM_BITS = SAMPLE_BITS + COUNT_BITS. The receiver cannot stall results.
// Every other transaction: result in the cycle after acceptance.
// Reset clears all but the sample and divider datapath registers; no clearing pass.
`timescale 1ns / 1ps

module imu_bias_calibrator_unit #(
    parameter int SAMPLE_BITS = ibc_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = ibc_pkg::COUNT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // command channel
    input  logic                              start,
    output logic                              busy,
    input  logic [ibc_pkg::FUNC_BITS-1:0]     func,
    input  logic [SAMPLE_BITS-1:0]            accel_x,
    input  logic [SAMPLE_BITS-1:0]            accel_y,
    input  logic [SAMPLE_BITS-1:0]            accel_z,
    input  logic [SAMPLE_BITS-1:0]            gyro_x,
    input  logic [SAMPLE_BITS-1:0]            gyro_y,
    input  logic [SAMPLE_BITS-1:0]            gyro_z,
    // result channel
    output logic                              done,
    output logic [ibc_pkg::STATUS_BITS-1:0]   status,
    output logic                              calibrating,
    output logic                              offsets_valid,
    output logic [ibc_pkg::OUT_BITS-1:0]      gyro_off_x,
    output logic [ibc_pkg::OUT_BITS-1:0]      gyro_off_y,
    output logic [ibc_pkg::OUT_BITS-1:0]      gyro_off_z,
    output logic [ibc_pkg::OUT_BITS-1:0]      accel_off_x,
    output logic [ibc_pkg::OUT_BITS-1:0]      accel_off_y,
    output logic [ibc_pkg::OUT_BITS-1:0]      accel_off_z,
    // configuration port
    input  logic                              cfg_we,
    input  logic [ibc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ibc_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

    localparam int SUM_BITS  = SAMPLE_BITS + COUNT_BITS;
    localparam int STEP_BITS = $clog2(SUM_BITS + 1);
    localparam int CMP_BITS  = (COUNT_BITS > ibc_pkg::MINS_BITS) ? COUNT_BITS
                                                                 : ibc_pkg::MINS_BITS;
    localparam int OB        = ibc_pkg::OUT_BITS;
    localparam int NA        = ibc_pkg::NUM_AXES;
    localparam int AB        = ibc_pkg::AXIS_BITS;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ACC  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;

    // configuration registers
    logic [ibc_pkg::DUR_BITS-1:0]  duration_reg;
    logic [ibc_pkg::GRAV_BITS-1:0] gravity_reg;
    logic [ibc_pkg::MINS_BITS-1:0] min_smp_reg;

    // control and state
    logic [1:0]                       state_reg, state_next;
    logic                             running_reg, running_next;
    logic [ibc_pkg::DUR_BITS-1:0]     elapsed_reg, elapsed_next;
    logic [COUNT_BITS-1:0]            count_reg, count_next;
    logic [STEP_BITS-1:0]             step_reg, step_next;
    logic [AB-1:0]                    axis_reg, axis_next;
    logic                             div_go_reg, div_go_next;
    logic                             done_reg, done_next;
    logic [ibc_pkg::STATUS_BITS-1:0]  status_reg, status_next;
    logic                             held_valid_reg, held_valid_next;
    logic [NA-1:0][OB-1:0]            held_reg, held_next;

    logic                             accept;
    logic [ibc_pkg::DUR_BITS-1:0]     el_inc;
    ibc_pkg::acc_ctl_t                acc_ctl;
    logic [NA-1:0][SAMPLE_BITS-1:0]   samples;
    logic [NA-1:0][SUM_BITS-1:0]      sums;
    logic                             div_done;
    logic [OB-1:0]                    div_result;

    assign busy   = state_reg != S_IDLE;
    assign accept = start && !busy;

    // gather samples in held-offset order: gyro x, y, z then accel x, y, z
    assign samples[0] = gyro_x;
    assign samples[1] = gyro_y;
    assign samples[2] = gyro_z;
    assign samples[3] = accel_x;
    assign samples[4] = accel_y;
    assign samples[5] = accel_z;

    // saturating tick count
    assign el_inc = (elapsed_reg != {ibc_pkg::DUR_BITS{1'b1}}) ? elapsed_reg + 1'b1
                                                                : elapsed_reg;

    // command decode and sequencing
    always_comb
    begin
        state_next      = state_reg;
        running_next    = running_reg;
        elapsed_next    = elapsed_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        axis_next       = axis_reg;
        div_go_next     = 1'b0;
        done_next       = 1'b0;
        status_next     = status_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        acc_ctl         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    done_next   = 1'b1;
                    status_next = ibc_pkg::STAT_TICK;
                    case (func)
                        ibc_pkg::FUNC_START:
                        begin
                            if (running_reg)
                            begin
                                status_next = ibc_pkg::STAT_BUSY;
                            end
                            else
                            begin
                                running_next  = 1'b1;
                                elapsed_next  = '0;
                                count_next    = '0;
                                acc_ctl.clear = 1'b1;
                                status_next   = ibc_pkg::STAT_STARTED;
                            end
                        end
                        ibc_pkg::FUNC_SAMPLE:
                        begin
                            status_next = ibc_pkg::STAT_SAMPLE;
                            if (running_reg && !(&count_reg))
                            begin
                                acc_ctl.load = 1'b1;
                                count_next   = count_reg + 1'b1;
                                step_next    = STEP_BITS'(SUM_BITS);
                                state_next   = S_ACC;
                                done_next    = 1'b0;
                            end
                        end
                        ibc_pkg::FUNC_TICK:
                        begin
                            if (running_reg)
                            begin
                                elapsed_next = el_inc;
                                if (el_inc >= duration_reg)
                                begin
                                    running_next = 1'b0;
                                    if (CMP_BITS'(count_reg) > CMP_BITS'(min_smp_reg))
                                    begin
                                        axis_next   = '0;
                                        div_go_next = 1'b1;
                                        state_next  = S_DIV;
                                        done_next   = 1'b0;
                                    end
                                    else
                                    begin
                                        status_next = ibc_pkg::STAT_INSUF;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ibc_pkg::STAT_TICK;
                        end
                    endcase
                end
            end
            S_ACC:
            begin
                // shift one bit of each sum per cycle
                acc_ctl.shift = 1'b1;
                step_next     = step_reg - 1'b1;
                if (step_reg == STEP_BITS'(1))
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                end
            end
            S_DIV:
            begin
                // store each average, then advance to the next axis
                if (div_done)
                begin
                    held_next[axis_reg] = div_result;
                    if (axis_reg == ibc_pkg::AXIS_ACCEL_Z)
                    begin
                        held_valid_next = 1'b1;
                        status_next     = ibc_pkg::STAT_VALID;
                        done_next       = 1'b1;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        axis_next   = axis_reg + 1'b1;
                        div_go_next = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            running_reg    <= 1'b0;
            elapsed_reg    <= '0;
            count_reg      <= '0;
            step_reg       <= '0;
            axis_reg       <= '0;
            div_go_reg     <= 1'b0;
            done_reg       <= 1'b0;
            status_reg     <= ibc_pkg::STAT_STARTED;
            held_valid_reg <= 1'b0;
            held_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            running_reg    <= running_next;
            elapsed_reg    <= elapsed_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            axis_reg       <= axis_next;
            div_go_reg     <= div_go_next;
            done_reg       <= done_next;
            status_reg     <= status_next;
            held_valid_reg <= held_valid_next;
            held_reg       <= held_next;
        end
    end

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duration_reg <= ibc_pkg::DURATION_RST;
            gravity_reg  <= ibc_pkg::GRAVITY_RST;
            min_smp_reg  <= ibc_pkg::MIN_SMP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ibc_pkg::CFG_DURATION: duration_reg <= cfg_wdata[ibc_pkg::DUR_BITS-1:0];
                ibc_pkg::CFG_GRAVITY:  gravity_reg  <= cfg_wdata[ibc_pkg::GRAV_BITS-1:0];
                ibc_pkg::CFG_MIN_SMP:  min_smp_reg  <= cfg_wdata[ibc_pkg::MINS_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ibc_serial_acc #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .SUM_BITS    (SUM_BITS)
    ) u_acc (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (acc_ctl),
        .samples (samples),
        .sums    (sums)
    );

    ibc_serial_div #(
        .SUM_BITS   (SUM_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go_reg),
        .is_z     (axis_reg == ibc_pkg::AXIS_ACCEL_Z),
        .dividend (sums[axis_reg]),
        .divisor  (count_reg),
        .gravity  (gravity_reg),
        .done     (div_done),
        .result   (div_result)
    );

    // result ports
    assign done          = done_reg;
    assign status        = status_reg;
    assign calibrating   = running_reg;
    assign offsets_valid = held_valid_reg;
    assign gyro_off_x    = held_reg[0];
    assign gyro_off_y    = held_reg[1];
    assign gyro_off_z    = held_reg[2];
    assign accel_off_x   = held_reg[3];
    assign accel_off_y   = held_reg[4];
    assign accel_off_z   = held_reg[5];

endmodule
